/* sv/psm_pkg.sv */
package psm_pkg;

    localparam int SigCount = 9;

    // Signature text, first character in the most significant byte.
    localparam logic [8*11-1:0] SigSql    = "' OR '1'='1";
    localparam logic [8*25-1:0] SigXssScr = "<script>alert(1)</script>";
    localparam logic [8*28-1:0] SigXssImg = "<img src=x onerror=alert(1)>";
    localparam logic [8*26-1:0] SigXssAlt = "<img src=x onerror=alert1>";
    localparam logic [8*9-1:0]  SigBash   = "/bin/bash";
    localparam logic [8*18-1:0] SigPasswd = "$(cat /etc/passwd)";
    localparam logic [7:0]      SigTick   = 8'h60;
    localparam logic [8*2-1:0]  SigSemi   = "; ";
    localparam logic [8*4-1:0]  SigNop    = 32'h9090_9090;

    typedef enum logic [1:0] {
        CLASS_NONE = 2'd0,
        CLASS_SQL  = 2'd1,
        CLASS_XSS  = 2'd2,
        CLASS_RCE  = 2'd3
    } threat_class_t;

    typedef struct packed {
        logic sql;
        logic xss;
        logic rce;
    } psm_hit_t;

    function automatic int sig_len(input int s);
        int n;
        begin
            case (s)
                0:       n = 11;
                1:       n = 25;
                2:       n = 28;
                3:       n = 26;
                4:       n = 9;
                5:       n = 18;
                6:       n = 1;
                7:       n = 2;
                8:       n = 4;
                default: n = 1;
            endcase
            return n;
        end
    endfunction

    function automatic threat_class_t sig_group(input int s);
        threat_class_t g;
        begin
            case (s)
                0:          g = CLASS_SQL;
                1, 2, 3:    g = CLASS_XSS;
                default:    g = CLASS_RCE;
            endcase
            return g;
        end
    endfunction

    // Character j of signature s, counting from its first character.
    function automatic logic [7:0] sig_char(input int s, input int j);
        logic [7:0] c;
        int         p;
        begin
            p = 8 * (sig_len(s) - 1 - j);
            case (s)
                0:       c = SigSql[p +: 8];
                1:       c = SigXssScr[p +: 8];
                2:       c = SigXssImg[p +: 8];
                3:       c = SigXssAlt[p +: 8];
                4:       c = SigBash[p +: 8];
                5:       c = SigPasswd[p +: 8];
                6:       c = SigTick;
                7:       c = SigSemi[p +: 8];
                8:       c = SigNop[p +: 8];
                default: c = 8'h00;
            endcase
            return c;
        end
    endfunction

endpackage

/* sv/psm_in_if.sv */
interface psm_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] payload_byte;
    logic       has_byte;
    logic       last_byte;

    modport source (output valid, output payload_byte, output has_byte, output last_byte,
                    input ready);
    modport sink   (input valid, input payload_byte, input has_byte, input last_byte,
                    output ready);
endinterface

/* sv/psm_out_if.sv */
interface psm_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] threat_class;

    modport source (output valid, output threat_class, input ready);
    modport sink   (input valid, input threat_class, output ready);
endinterface

/* sv/payload_signature_matcher.sv */
// Channel  | Direction | Handshake   | Carries
// payload  | in        | valid/ready | payload_byte, has_byte, last_byte
// verdict  | out       | valid/ready | threat_class, one per packet
//
// One byte a cycle: a transfer on payload is taken every cycle while the
// verdict register is empty or being drained in the same cycle.
// A verdict appears in the cycle after the transfer marked last_byte.
// Reset clears every match cell, the group flags and the verdict valid flag, but not the verdict class.
// A stalled verdict holds payload off; no other stall source exists.
module payload_signature_matcher (
    input  logic      clk,
    input  logic      rst_n,
    psm_in_if.sink    payload,
    psm_out_if.source verdict
);

    logic              in_acc;
    logic              shift;
    logic              clr;
    psm_pkg::psm_hit_t hits;

    logic              sql_reg;
    logic              sql_next;
    logic              xss_reg;
    logic              xss_next;
    logic              rce_reg;
    logic              rce_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [1:0]        class_reg;
    logic [1:0]        class_next;

    // Take a new transfer whenever the verdict slot frees up this cycle.
    assign payload.ready = !out_valid_reg || verdict.ready;
    assign in_acc        = payload.valid && payload.ready;
    assign shift         = in_acc && payload.has_byte;
    assign clr           = in_acc && payload.last_byte;

    // Chain of compare cells: one cell per signature character, each holding
    // whether the signature prefix up to it ended at the previous byte.
    psm_cell_row u_row (
        .clk   (clk),
        .rst_n (rst_n),
        .cur   (payload.payload_byte),
        .shift (shift),
        .clr   (clr),
        .hits  (hits)
    );

    // Sticky flags, including a hit on the closing byte itself.
    assign sql_next = sql_reg | hits.sql;
    assign xss_next = xss_reg | hits.xss;
    assign rce_next = rce_reg | hits.rce;

    always_comb
    begin
        // Priority: SQL over XSS over RCE.
        if (sql_next)
        begin
            class_next = psm_pkg::CLASS_SQL;
        end
        else if (xss_next)
        begin
            class_next = psm_pkg::CLASS_XSS;
        end
        else if (rce_next)
        begin
            class_next = psm_pkg::CLASS_RCE;
        end
        else
        begin
            class_next = psm_pkg::CLASS_NONE;
        end

        out_valid_next = out_valid_reg && !verdict.ready;
        if (clr)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sql_reg       <= 1'b0;
            xss_reg       <= 1'b0;
            rce_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (clr)
            begin
                // Drop the packet's flags once its verdict is captured.
                sql_reg <= 1'b0;
                xss_reg <= 1'b0;
                rce_reg <= 1'b0;
            end
            else if (shift)
            begin
                sql_reg <= sql_next;
                xss_reg <= xss_next;
                rce_reg <= rce_next;
            end
        end
    end

    // Verdict class register: load only on the closing transfer.
    always_ff @(posedge clk)
    begin
        if (clr)
        begin
            class_reg <= class_next;
        end
    end

    assign verdict.valid        = out_valid_reg;
    assign verdict.threat_class = class_reg;

    a_verdict_from_last: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(clr))
        else $error("verdict raised without a closing transfer");

    a_flags_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        clr |=> (!sql_reg && !xss_reg && !rce_reg))
        else $error("group flags survive the end of a packet");

    a_sql_priority: assert property (@(posedge clk) disable iff (!rst_n)
        (clr && sql_next) |=> (class_reg == psm_pkg::CLASS_SQL))
        else $error("SQL hit not reported first");

    a_rce_only: assert property (@(posedge clk) disable iff (!rst_n)
        (clr && rce_next && !sql_next && !xss_next) |=> (class_reg == psm_pkg::CLASS_RCE))
        else $error("RCE hit lost");

endmodule

/* sv/psm_cell.sv */
module psm_cell (
    input  logic       clk,
    input  logic       rst_n,
    input  logic [7:0] cur,
    input  logic [7:0] expect_char,
    input  logic       shift,
    input  logic       clr,
    input  logic       prev,
    output logic       hit,
    output logic       matched
);

    logic match_reg;
    logic match_next;

    // Prefix up to this cell ends at the current byte.
    assign hit = prev && (cur == expect_char);

    always_comb
    begin
        match_next = match_reg;
        if (clr)
        begin
            match_next = 1'b0;
        end
        else if (shift)
        begin
            match_next = hit;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_reg <= 1'b0;
        end
        else
        begin
            match_reg <= match_next;
        end
    end

    assign matched = match_reg;

endmodule

/* sv/psm_cell_row.sv */
module psm_cell_row (
    input  logic             clk,
    input  logic             rst_n,
    input  logic [7:0]       cur,
    input  logic             shift,
    input  logic             clr,
    output psm_pkg::psm_hit_t hits
);

    logic [psm_pkg::SigCount-1:0] sig_hit;

    for (genvar s = 0; s < psm_pkg::SigCount; s++)
    begin : g_sig
        localparam int Len = psm_pkg::sig_len(s);
        logic [Len-1:0] cell_hit;
        logic [Len-1:0] cell_match;

        for (genvar j = 0; j < Len; j++)
        begin : g_cell
            logic prev;
            if (j == 0)
            begin : g_head
                assign prev = 1'b1;
            end
            else
            begin : g_link
                assign prev = cell_match[j-1];
            end

            psm_cell u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .cur         (cur),
                .expect_char (psm_pkg::sig_char(s, j)),
                .shift       (shift),
                .clr         (clr),
                .prev        (prev),
                .hit         (cell_hit[j]),
                .matched     (cell_match[j])
            );
        end

        // The tail cell's stored prefix is never needed by a later cell.
        assign sig_hit[s] = shift && cell_hit[Len-1];
    end

    always_comb
    begin
        hits = '0;
        for (int s = 0; s < psm_pkg::SigCount; s++)
        begin
            case (psm_pkg::sig_group(s))
                psm_pkg::CLASS_SQL: hits.sql = hits.sql | sig_hit[s];
                psm_pkg::CLASS_XSS: hits.xss = hits.xss | sig_hit[s];
                default:            hits.rce = hits.rce | sig_hit[s];
            endcase
        end
    end

endmodule
